>>> hw/rtl/rfbe_pkg.sv
// Package for the raster fill and blit engine: command codes, pixel format codes,
// and the command record passed from the front end to the back end. No dependencies.
`default_nettype none
package rfbe_pkg;
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_BLIT  = 2'd3
    } t_cmd;

    localparam logic [2:0] FMT_4BPP = 3'd0;
    localparam logic [2:0] FMT_MAX  = 3'd4;

    localparam logic [3:0] REG_DEST_PITCH  = 4'd0;
    localparam logic [3:0] REG_DEST_WIDTH  = 4'd1;
    localparam logic [3:0] REG_DEST_HEIGHT = 4'd2;
    localparam logic [3:0] REG_SRC_BASE    = 4'd3;
    localparam logic [3:0] REG_SRC_PITCH   = 4'd4;
    localparam logic [3:0] REG_SRC_WIDTH   = 4'd5;
    localparam logic [3:0] REG_SRC_HEIGHT  = 4'd6;
    localparam logic [3:0] REG_PIXEL_FMT   = 4'd7;

    // A classified command: the rectangle is already clipped, the skip is decided.
    typedef struct packed {
        t_cmd        cmd;
        logic        skip;
        logic [15:0] address;
        logic [7:0]  wdata;
        logic [31:0] color;
        logic [16:0] cols;     // columns (pixels) per row
        logic [16:0] rows;
        logic [16:0] src_x;
        logic [16:0] src_y;
        logic [16:0] dst_x;
        logic [16:0] dst_y;
    } t_job;
endpackage
`default_nettype wire

>>> hw/rtl/rfbe_front.sv
// Front end of the raster engine: takes commands, clips blit rectangles and
// classifies them into jobs via stage 1 and a job register. Depends on rfbe_pkg.
`default_nettype none
module rfbe_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [1:0]      i_command,
    input  wire logic [15:0]     i_address,
    input  wire logic [7:0]      i_write_byte,
    input  wire logic [31:0]     i_fill_color,
    input  wire logic [11:0]     i_dest_x,
    input  wire logic [11:0]     i_dest_y,
    input  wire logic [12:0]     i_src_left,
    input  wire logic [12:0]     i_src_top,
    input  wire logic [12:0]     i_src_right,
    input  wire logic [12:0]     i_src_bottom,
    input  wire logic [16:0]     i_dw,
    input  wire logic [16:0]     i_dh,
    input  wire logic [16:0]     i_sw,
    input  wire logic [16:0]     i_sh,
    input  wire logic [2:0]      i_fmt,
    output logic                 o_valid,
    output rfbe_pkg::t_job       o_job
);
    // Stage 1 holds the raw command with clamped source edges.
    logic            r_s1_valid;
    rfbe_pkg::t_job  r_s1;
    logic [16:0]     r_right, r_bottom;
    logic            r_valid;
    rfbe_pkg::t_job  r_job;

    logic [16:0] n_right, n_bottom, cw, ch, dw, dh, dxe, dye;
    logic        skip;
    rfbe_pkg::t_job n_job;

    always_comb begin
        n_right  = (17'(i_src_right) > i_sw) ? i_sw : 17'(i_src_right);
        n_bottom = (17'(i_src_bottom) > i_sh) ? i_sh : 17'(i_src_bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_take;
        end
        if (i_take) begin
            r_s1.cmd     <= rfbe_pkg::t_cmd'(i_command);
            r_s1.skip    <= 1'b0;
            r_s1.address <= i_address;
            r_s1.wdata   <= i_write_byte;
            r_s1.color   <= i_fill_color;
            r_s1.cols    <= '0;
            r_s1.rows    <= '0;
            r_s1.src_x   <= 17'(i_src_left);
            r_s1.src_y   <= 17'(i_src_top);
            r_s1.dst_x   <= 17'(i_dest_x);
            r_s1.dst_y   <= 17'(i_dest_y);
            r_right      <= n_right;
            r_bottom     <= n_bottom;
        end
    end

    always_comb begin
        dw  = i_dw;
        dh  = i_dh;
        cw  = r_right - r_s1.src_x;
        ch  = r_bottom - r_s1.src_y;
        dxe = r_s1.dst_x + cw;
        dye = r_s1.dst_y + ch;
        skip = (i_fmt > rfbe_pkg::FMT_MAX) || (r_s1.src_x >= r_right)
            || (r_s1.src_y >= r_bottom) || (r_s1.dst_x >= dw) || (r_s1.dst_y >= dh);
        if (dxe > dw) cw = dw - r_s1.dst_x;
        if (dye > dh) ch = dh - r_s1.dst_y;
    end

    // A fill always covers the whole destination from its first byte.
    always_comb begin
        n_job      = r_s1;
        n_job.skip = (r_s1.cmd == rfbe_pkg::CMD_BLIT) && skip;
        if (r_s1.cmd == rfbe_pkg::CMD_FILL) begin
            n_job.cols  = dw;
            n_job.rows  = dh;
            n_job.dst_x = '0;
            n_job.dst_y = '0;
        end else begin
            n_job.cols = cw;
            n_job.rows = ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s1_valid;
        end
        if (r_s1_valid) r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

>>> hw/rtl/rfbe_queue.sv
// Short job queue between the front and back ends of the raster engine.
// Depends on rfbe_pkg.
`default_nettype none
module rfbe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  rfbe_pkg::t_job      i_job,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rfbe_pkg::t_job      o_job
);
    rfbe_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_q[r_wp] <= i_job;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
endmodule
`default_nettype wire

>>> hw/rtl/rfbe_back.sv
// Back end of the raster engine: owns the pixel memory and carries out one job
// at a time, one memory access per cycle. Depends on rfbe_pkg.
`default_nettype none
module rfbe_back #(
    parameter int AW = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  rfbe_pkg::t_job      i_job,
    output logic                o_pop,
    input  wire logic [15:0]    i_dest_pitch,
    input  wire logic [15:0]    i_src_base,
    input  wire logic [15:0]    i_src_pitch,
    input  wire logic [2:0]     i_fmt,
    output logic                o_done,
    output logic [7:0]          o_read_byte,
    output logic                o_status
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SETUP = 8'b0000_0010,
        ST_RD    = 8'b0000_0100,
        ST_RWAIT = 8'b0000_1000,
        ST_SRD   = 8'b0001_0000,
        ST_DRD   = 8'b0010_0000,
        ST_WR    = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    logic [7:0]     r_mem [2**AW];
    logic [7:0]     r_rdata;
    t_state         r_st;
    rfbe_pkg::t_job r_job;
    logic [16:0]    r_col, r_row, r_ncols;
    logic [2:0]     r_bi;            // byte within pixel
    logic [2:0]     r_bpp;
    logic [AW-1:0]  r_srow, r_drow;  // row base addresses
    logic [AW-1:0]  r_sa, r_da;
    logic [7:0]     r_sbyte;
    logic [7:0]     r_out;
    logic           r_stat;
    logic           r_done;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [7:0]     wdata;
    logic           is4;
    logic [16:0]    sx, tx;
    logic [3:0]     nib;

    // Address of the next byte of the current row, from the column counter.
    logic [AW-1:0] sa_nx, da_nx;
    logic [16:0]   sbyte_off, dbyte_off;

    assign is4 = (i_fmt == rfbe_pkg::FMT_4BPP);
    assign sx  = r_job.src_x + r_col;
    assign tx  = r_job.dst_x + r_col;
    assign nib = sx[0] ? r_sbyte[7:4] : r_sbyte[3:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_da;
        wdata = r_rdata;
        raddr = r_sa;
        case (r_st)
            ST_RD:  raddr = AW'(r_job.address);
            ST_SRD: raddr = sa_nx;
            ST_DRD: raddr = r_da;
            ST_WR: begin
                we = 1'b1;
                case (r_job.cmd)
                    rfbe_pkg::CMD_WRITE: begin
                        waddr = AW'(r_job.address);
                        wdata = r_job.wdata;
                    end
                    rfbe_pkg::CMD_FILL: begin
                        if (is4) wdata = {r_job.color[3:0], r_job.color[3:0]};
                        else     wdata = r_job.color[8*r_bi +: 8];
                    end
                    default: begin
                        if (is4) wdata = tx[0] ? {nib, r_rdata[3:0]} : {r_rdata[7:4], nib};
                        else     wdata = r_sbyte;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        if (r_job.cmd == rfbe_pkg::CMD_FILL) begin
            sbyte_off = r_col;
            dbyte_off = r_col;
        end else if (is4) begin
            sbyte_off = {1'b0, sx[16:1]};
            dbyte_off = {1'b0, tx[16:1]};
        end else begin
            sbyte_off = r_job.src_x * 17'(r_bpp) + r_col;
            dbyte_off = r_job.dst_x * 17'(r_bpp) + r_col;
        end
        sa_nx = r_srow + AW'(sbyte_off);
        da_nx = r_drow + AW'(dbyte_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_st == ST_DONE);
            case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_st  <= ST_SETUP;
                end
                ST_SETUP: begin
                    r_out  <= '0;
                    r_stat <= r_job.skip;
                    r_col  <= '0;
                    r_row  <= '0;
                    r_bi   <= '0;
                    r_bpp  <= (i_fmt == rfbe_pkg::FMT_4BPP) ? 3'd1 : i_fmt;
                    r_srow <= AW'(i_src_base + 32'(r_job.src_y) * 32'(i_src_pitch));
                    r_drow <= AW'(32'(r_job.dst_y) * 32'(i_dest_pitch));
                    if (r_job.cmd == rfbe_pkg::CMD_FILL)
                        r_ncols <= is4 ? {1'b0, r_job.cols[16:1]}
                                       : r_job.cols * 17'(i_fmt);
                    else
                        r_ncols <= is4 ? r_job.cols : r_job.cols * 17'(i_fmt);
                    case (r_job.cmd)
                        rfbe_pkg::CMD_WRITE: r_st <= ST_WR;
                        rfbe_pkg::CMD_READ:  r_st <= ST_RD;
                        rfbe_pkg::CMD_FILL:
                            r_st <= (i_fmt > rfbe_pkg::FMT_MAX) ? ST_DONE : ST_SRD;
                        default: r_st <= r_job.skip ? ST_DONE : ST_SRD;
                    endcase
                end
                ST_RD: r_st <= ST_RWAIT;
                ST_RWAIT: begin
                    r_out <= r_rdata;
                    r_st  <= ST_DONE;
                end
                ST_SRD: begin
                    // First visit per element: check end of row / end of job.
                    if (r_row >= r_job.rows) begin
                        r_st <= ST_DONE;
                    end else if (r_col >= r_ncols) begin
                        r_col  <= '0;
                        r_bi   <= '0;
                        r_row  <= r_row + 17'd1;
                        r_srow <= r_srow + AW'(i_src_pitch);
                        r_drow <= r_drow + AW'(i_dest_pitch);
                    end else begin
                        r_sa <= sa_nx;
                        r_da <= da_nx;
                        r_st <= (r_job.cmd == rfbe_pkg::CMD_FILL) ? ST_WR : ST_DRD;
                    end
                end
                ST_DRD: begin
                    // Source byte arrives now; the destination byte is read in this state.
                    r_sbyte <= r_rdata;
                    r_st    <= ST_WR;
                end
                ST_WR: begin
                    if (r_job.cmd == rfbe_pkg::CMD_WRITE) begin
                        r_st <= ST_DONE;
                    end else begin
                        r_col <= r_col + 17'd1;
                        r_bi  <= (r_bi + 3'd1 == r_bpp) ? 3'd0 : r_bi + 3'd1;
                        r_st  <= ST_SRD;
                    end
                end
                ST_DONE: begin
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // For an 8 bpp and wider copy WR stores the source byte captured in DRD;
    // at 4 bpp WR merges its nibble into the destination byte read in DRD.
    assign o_pop       = (r_st == ST_IDLE) && i_valid;
    assign o_done      = r_done;
    assign o_read_byte = r_out;
    assign o_status    = r_stat;
endmodule
`default_nettype wire

>>> hw/rtl/raster_fill_and_blit_engine_unit.sv
// Top level of the raster fill and blit engine: configuration registers and
// the front end, job queue and back end. Depends on rfbe_pkg, rfbe_front, rfbe_queue, rfbe_back.
//
// A user writes the registers through i_cfg_we/i_cfg_index/i_cfg_data while idle,
// then raises start with a request; the request is accepted when start is
// high and busy is low. The single result on o_read_byte and o_status is valid
// while o_done is high for a single cycle; the receiver cannot stall it. A write
// passes the back end through SETUP, WR and DONE, a read through SETUP, RD, RWAIT
// and DONE; a fill visits SRD and WR for each byte it stores and a blit SRD, DRD
// and WR for each byte (each pixel at 4 bpp), and each row ends with one more
// visit to SRD. Widths and heights above MAX_DIM count as MAX_DIM; all addresses
// wrap at MEM_BYTES.
`default_nettype none
module raster_fill_and_blit_engine_unit #(
    parameter int MEM_BYTES = 65536,
    parameter int MAX_DIM   = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    output logic             o_done,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic [31:0] i_fill_color,
    input  wire logic [11:0] i_dest_x,
    input  wire logic [11:0] i_dest_y,
    input  wire logic [12:0] i_src_left,
    input  wire logic [12:0] i_src_top,
    input  wire logic [12:0] i_src_right,
    input  wire logic [12:0] i_src_bottom,
    output logic [7:0]       o_read_byte,
    output logic             o_status
);
    localparam int AW = $clog2(MEM_BYTES);

    logic [15:0] r_dest_pitch, r_src_base, r_src_pitch;
    logic [12:0] r_dest_width, r_dest_height, r_src_width, r_src_height;
    logic [2:0]  r_fmt;
    logic        r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_pitch <= '0; r_dest_width <= '0; r_dest_height <= '0;
            r_src_base <= '0; r_src_pitch <= '0; r_src_width <= '0;
            r_src_height <= '0; r_fmt <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rfbe_pkg::REG_DEST_PITCH:  r_dest_pitch  <= i_cfg_data;
                rfbe_pkg::REG_DEST_WIDTH:  r_dest_width  <= i_cfg_data[12:0];
                rfbe_pkg::REG_DEST_HEIGHT: r_dest_height <= i_cfg_data[12:0];
                rfbe_pkg::REG_SRC_BASE:    r_src_base    <= i_cfg_data;
                rfbe_pkg::REG_SRC_PITCH:   r_src_pitch   <= i_cfg_data;
                rfbe_pkg::REG_SRC_WIDTH:   r_src_width   <= i_cfg_data[12:0];
                rfbe_pkg::REG_SRC_HEIGHT:  r_src_height  <= i_cfg_data[12:0];
                rfbe_pkg::REG_PIXEL_FMT:   r_fmt         <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Dimension clamp to MAX_DIM.
    function automatic logic [16:0] clampd(input logic [12:0] v);
        return (17'(v) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(v);
    endfunction

    logic take;
    assign take = start && !r_busy;
    // The block runs one request at a time: busy from accept until the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    logic           f_valid, q_valid, pop;
    rfbe_pkg::t_job f_job, q_job;

    rfbe_front u_front (
        .i_clk, .i_rst_n, .i_take(take),
        .i_command, .i_address, .i_write_byte, .i_fill_color,
        .i_dest_x, .i_dest_y, .i_src_left, .i_src_top, .i_src_right, .i_src_bottom,
        .i_dw(clampd(r_dest_width)), .i_dh(clampd(r_dest_height)),
        .i_sw(clampd(r_src_width)), .i_sh(clampd(r_src_height)),
        .i_fmt(r_fmt), .o_valid(f_valid), .o_job(f_job)
    );

    rfbe_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_job(f_job),
        .i_pop(pop), .o_valid(q_valid), .o_job(q_job)
    );

    rfbe_back #(.AW(AW)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_job(q_job), .o_pop(pop),
        .i_dest_pitch(r_dest_pitch), .i_src_base(r_src_base),
        .i_src_pitch(r_src_pitch), .i_fmt(r_fmt),
        .o_done, .o_read_byte, .o_status
    );
endmodule
`default_nettype wire

>>> hw/rtl/rfbe_checker.sv
// Port-level checker for the raster engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rfbe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [7:0] o_read_byte,
    input wire logic       o_status
);
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result while idle");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");
    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy after result");
    // A skipped blit never carries read data.
    a_skip_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_read_byte == 8'd0)) else $error("data on skip");
endmodule

bind raster_fill_and_blit_engine_unit rfbe_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_read_byte, .o_status
);
`default_nettype wire
